// ===== sv/c6309_pkg.sv =====
// ----------------------------------------------------------------------------
// c6309_pkg
// Shared types and codes for the 6309 microstate step block.
// ----------------------------------------------------------------------------
package c6309_pkg;

  typedef enum logic [1:0] {
    MODE_POSTINC = 2'd0,
    MODE_ADDA    = 2'd1,
    MODE_ADDD    = 2'd2,
    MODE_TFM     = 2'd3
  } mode_t;

  localparam int unsigned NUM_INDEX = 4;

  localparam int unsigned CC_C = 0;
  localparam int unsigned CC_V = 1;
  localparam int unsigned CC_Z = 2;
  localparam int unsigned CC_N = 3;
  localparam int unsigned CC_I = 4;
  localparam int unsigned CC_H = 5;
  localparam int unsigned CC_F = 6;

  localparam int unsigned PEND_NMI  = 0;
  localparam int unsigned PEND_IRQ  = 1;
  localparam int unsigned PEND_FIRQ = 2;
  localparam int unsigned PEND_HALT = 3;

  typedef struct packed {
    logic       halt_n;
    logic [2:0] ctrl_lines_n;
    logic [7:0] data_bus;
    logic [7:0] postbyte;
    mode_t      mode;
  } in_item_t;

endpackage

// ===== sv/cpu6309_microstate_step.sv =====
// ----------------------------------------------------------------------------
// cpu6309_microstate_step
// Runs one 6309 microstate per request and samples the interrupt and halt
// pins into sticky pending bits.
// ----------------------------------------------------------------------------
// A request is taken into the input register; its result is then registered in
// the result register once that register is free or being read out.
// Throughput: one request per cycle unless the output stalls; the state update
// and flag logic sit in the single stage between the input and result registers.
// Reset: synchronous, active high; clears all CPU state and both valid bits.
module cpu6309_microstate_step (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // postbyte, data_bus, ctrl_lines_n, halt_n, zero pad
  input  logic [1:0]  s_tuser,   // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // effective_addr, pending_out, cc_out, acc_a_out,
                                 // acc_b_out, zero pad
);

  c6309_pkg::in_item_t in_item;
  logic                in_valid;
  logic                advance;

  logic [15:0] idx [c6309_pkg::NUM_INDEX];
  logic [15:0] idx_next [c6309_pkg::NUM_INDEX];
  logic [7:0]  acc_a, acc_a_next;
  logic [7:0]  acc_b, acc_b_next;
  logic [15:0] acc_w, acc_w_next;
  logic [7:0]  cc, cc_next;
  logic [15:0] ea, ea_next;
  logic [3:0]  pending, pending_next;
  logic [2:0]  prev_ctrl;
  logic [2:0]  now_ctrl;

  logic [1:0]  sel_pi;
  logic [1:0]  sel_src;
  logic [1:0]  sel_dst;
  logic [8:0]  sum_a;
  logic [4:0]  half_x;
  logic [16:0] sum_d;
  logic [15:0] acc_d;

  logic        out_valid;
  logic [47:0] out_data;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item <= {s_tdata[19:0], c6309_pkg::mode_t'(s_tuser)};
    end
  end

  assign sel_pi  = in_item.postbyte[6:5];
  assign sel_src = in_item.postbyte[5:4];
  assign sel_dst = in_item.postbyte[1:0];
  assign acc_d   = {acc_a, acc_b};
  assign sum_a   = {1'b0, acc_a} + {1'b0, in_item.data_bus};
  assign half_x  = acc_a[4:0] ^ in_item.data_bus[4:0] ^ sum_a[4:0];
  assign sum_d   = {1'b0, acc_d} + {1'b0, ea};
  assign now_ctrl = ~in_item.ctrl_lines_n;

  always_comb begin
    for (int i = 0; i < c6309_pkg::NUM_INDEX; i++) begin
      idx_next[i] = idx[i];
    end
    acc_a_next = acc_a;
    acc_b_next = acc_b;
    acc_w_next = acc_w;
    cc_next    = cc;
    ea_next    = ea;
    unique case (in_item.mode)
      c6309_pkg::MODE_POSTINC: begin
        ea_next = idx[sel_pi];
        for (int i = 0; i < c6309_pkg::NUM_INDEX; i++) begin
          if (sel_pi == 2'(i)) begin
            idx_next[i] = idx[i] + 16'd1 + {15'd0, in_item.postbyte[0]};
          end
        end
      end
      c6309_pkg::MODE_ADDA: begin
        acc_a_next       = sum_a[7:0];
        cc_next[c6309_pkg::CC_C] = sum_a[8];
        cc_next[c6309_pkg::CC_V] = (acc_a[7] ^ sum_a[7]) & (in_item.data_bus[7] ^ sum_a[7]);
        cc_next[c6309_pkg::CC_Z] = (sum_a[7:0] == 8'd0);
        cc_next[c6309_pkg::CC_N] = sum_a[7];
        cc_next[c6309_pkg::CC_H] = half_x[4];
      end
      c6309_pkg::MODE_ADDD: begin
        acc_a_next       = sum_d[15:8];
        acc_b_next       = sum_d[7:0];
        cc_next[c6309_pkg::CC_C] = sum_d[16];
        cc_next[c6309_pkg::CC_V] = (acc_d[15] ^ sum_d[15]) & (ea[15] ^ sum_d[15]);
        cc_next[c6309_pkg::CC_Z] = (sum_d[15:0] == 16'd0);
        cc_next[c6309_pkg::CC_N] = sum_d[15];
      end
      c6309_pkg::MODE_TFM: begin
        acc_w_next = acc_w - 16'd1;
        for (int i = 0; i < c6309_pkg::NUM_INDEX; i++) begin
          idx_next[i] = idx[i] + {15'd0, sel_src == 2'(i)} + {15'd0, sel_dst == 2'(i)};
        end
      end
      default: begin
        ea_next = ea;
      end
    endcase
  end

  always_comb begin
    pending_next = pending;
    pending_next[c6309_pkg::PEND_NMI]  = pending[c6309_pkg::PEND_NMI] |
                                         (now_ctrl[0] & ~prev_ctrl[0]);
    pending_next[c6309_pkg::PEND_IRQ]  = pending[c6309_pkg::PEND_IRQ] |
                                         (now_ctrl[1] & ~cc_next[c6309_pkg::CC_I]);
    pending_next[c6309_pkg::PEND_FIRQ] = pending[c6309_pkg::PEND_FIRQ] |
                                         (now_ctrl[2] & ~cc_next[c6309_pkg::CC_F]);
    pending_next[c6309_pkg::PEND_HALT] = pending[c6309_pkg::PEND_HALT] | ~in_item.halt_n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < c6309_pkg::NUM_INDEX; i++) begin
        idx[i] <= 16'd0;
      end
      acc_a     <= 8'd0;
      acc_b     <= 8'd0;
      acc_w     <= 16'd0;
      cc        <= 8'd0;
      ea        <= 16'd0;
      pending   <= 4'd0;
      prev_ctrl <= 3'd0;
    end else if (advance) begin
      for (int i = 0; i < c6309_pkg::NUM_INDEX; i++) begin
        idx[i] <= idx_next[i];
      end
      acc_a     <= acc_a_next;
      acc_b     <= acc_b_next;
      acc_w     <= acc_w_next;
      cc        <= cc_next;
      ea        <= ea_next;
      pending   <= pending_next;
      prev_ctrl <= now_ctrl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= {4'd0, acc_b_next, acc_a_next, cc_next, pending_next, ea_next};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  a_pending_sticky: assert property (@(posedge clk) disable iff (rst)
    (pending & $past(pending)) == $past(pending))
    else $error("pending bit cleared");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |-> !s_tready)
    else $error("request taken while input register held");

  a_out_from_advance: assert property (@(posedge clk) disable iff (rst)
    !out_valid |=> (out_valid == $past(advance)))
    else $error("result valid without a step");

  a_ea_only_postinc: assert property (@(posedge clk) disable iff (rst)
    (advance && in_item.mode != c6309_pkg::MODE_POSTINC) |=> ea == $past(ea))
    else $error("effective address changed outside post-increment");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives 6309 microstate requests into the step block and checks each result
// against a cycle-free model of the CPU state. A table of directed requests
// covers every microstate and each pin case. About 950 random requests follow,
// with random gaps on both sides, one long output stall and one drain pause.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned NDIR        = 25;
  localparam int unsigned NRAND       = 950;
  localparam int unsigned CALM_FROM   = 830;
  localparam int unsigned DRAIN_AT    = 450;
  localparam int unsigned BACKLOG_AT  = 300;
  localparam int unsigned BACKLOG_LEN = 200;
  localparam int unsigned STUCK_LIMIT = 2000;

  typedef struct packed {
    logic [15:0] ea;
    logic [3:0]  pend;
    logic [7:0]  cc;
    logic [7:0]  acc_a;
    logic [7:0]  acc_b;
  } step_result_t;

  typedef struct packed {
    c6309_pkg::mode_t mode;
    logic [7:0]       postbyte;
    logic [7:0]       data_bus;
    logic [2:0]       lines_n;
    logic             halt_n;
    logic             typed;
    step_result_t     want;
  } dir_row_t;

  localparam dir_row_t DIRECTED [NDIR] = '{
    '{c6309_pkg::MODE_POSTINC, 8'h00, 8'h00, 3'b111, 1'b1, 1'b1,
      '{16'h0000, 4'h0, 8'h00, 8'h00, 8'h00}},
    '{c6309_pkg::MODE_POSTINC, 8'h21, 8'h00, 3'b111, 1'b1, 1'b1,
      '{16'h0000, 4'h0, 8'h00, 8'h00, 8'h00}},
    '{c6309_pkg::MODE_POSTINC, 8'hDE, 8'h00, 3'b111, 1'b1, 1'b1,
      '{16'h0000, 4'h0, 8'h00, 8'h00, 8'h00}},
    '{c6309_pkg::MODE_POSTINC, 8'hFF, 8'h00, 3'b111, 1'b1, 1'b1,
      '{16'h0000, 4'h0, 8'h00, 8'h00, 8'h00}},
    '{c6309_pkg::MODE_POSTINC, 8'h00, 8'h00, 3'b111, 1'b1, 1'b1,
      '{16'h0001, 4'h0, 8'h00, 8'h00, 8'h00}},
    '{c6309_pkg::MODE_ADDA,    8'h00, 8'hFF, 3'b111, 1'b1, 1'b1,
      '{16'h0001, 4'h0, 8'h08, 8'hFF, 8'h00}},
    '{c6309_pkg::MODE_ADDA,    8'h00, 8'h01, 3'b111, 1'b1, 1'b1,
      '{16'h0001, 4'h0, 8'h25, 8'h00, 8'h00}},
    '{c6309_pkg::MODE_ADDA,    8'h00, 8'h00, 3'b111, 1'b1, 1'b0, '0},
    '{c6309_pkg::MODE_ADDA,    8'h00, 8'h7F, 3'b111, 1'b1, 1'b0, '0},
    '{c6309_pkg::MODE_ADDA,    8'h00, 8'h01, 3'b111, 1'b1, 1'b0, '0},
    '{c6309_pkg::MODE_ADDA,    8'h00, 8'h80, 3'b111, 1'b1, 1'b0, '0},
    '{c6309_pkg::MODE_ADDD,    8'h00, 8'h00, 3'b111, 1'b1, 1'b0, '0},
    '{c6309_pkg::MODE_POSTINC, 8'h7F, 8'h00, 3'b111, 1'b1, 1'b0, '0},
    '{c6309_pkg::MODE_ADDD,    8'h00, 8'h00, 3'b111, 1'b1, 1'b0, '0},
    '{c6309_pkg::MODE_TFM,     8'h00, 8'h00, 3'b111, 1'b1, 1'b0, '0},
    '{c6309_pkg::MODE_TFM,     8'h32, 8'h00, 3'b111, 1'b1, 1'b0, '0},
    '{c6309_pkg::MODE_TFM,     8'hFF, 8'h00, 3'b111, 1'b1, 1'b0, '0},
    '{c6309_pkg::MODE_TFM,     8'hCD, 8'h00, 3'b111, 1'b1, 1'b0, '0},
    '{c6309_pkg::MODE_POSTINC, 8'h40, 8'h00, 3'b110, 1'b1, 1'b0, '0},
    '{c6309_pkg::MODE_POSTINC, 8'h20, 8'h00, 3'b110, 1'b1, 1'b0, '0},
    '{c6309_pkg::MODE_ADDA,    8'h00, 8'h55, 3'b111, 1'b1, 1'b0, '0},
    '{c6309_pkg::MODE_ADDA,    8'h00, 8'hAA, 3'b101, 1'b1, 1'b0, '0},
    '{c6309_pkg::MODE_ADDD,    8'h00, 8'h00, 3'b011, 1'b1, 1'b0, '0},
    '{c6309_pkg::MODE_TFM,     8'h00, 8'h00, 3'b000, 1'b0, 1'b0, '0},
    '{c6309_pkg::MODE_POSTINC, 8'h01, 8'hFF, 3'b111, 1'b1, 1'b0, '0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [1:0]  s_tuser = c6309_pkg::MODE_POSTINC;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;

  logic [15:0] ptr_file [c6309_pkg::NUM_INDEX] = '{default: '0};
  logic [7:0]  a_reg = '0;
  logic [7:0]  b_reg = '0;
  logic [7:0]  e_reg = '0;
  logic [7:0]  f_reg = '0;
  logic [7:0]  cc_reg = '0;
  logic [15:0] ea_reg = '0;
  logic [3:0]  pend_reg = '0;
  logic [2:0]  pins_last = '0;

  step_result_t step_results_due [$];
  int unsigned  steps_issued = 0;
  int unsigned  steps_retired = 0;
  int unsigned  fault_count = 0;
  int unsigned  stuck_cycles = 0;
  bit           calm_phase = 1'b0;
  bit           backlog_done = 1'b0;

  cpu6309_microstate_step dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #4 clk = ~clk;

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  function automatic step_result_t run_microstate(c6309_pkg::in_item_t req);
    logic [1:0]   sel;
    logic [1:0]   dst;
    logic [8:0]   sum8;
    logic [7:0]   carries;
    logic [15:0]  d_val;
    logic [16:0]  sum16;
    logic [2:0]   pins_now;
    step_result_t res;
    case (req.mode)
      c6309_pkg::MODE_POSTINC: begin
        sel = req.postbyte[6:5];
        ea_reg = ptr_file[sel];
        ptr_file[sel] = ptr_file[sel] + 16'd1 + {15'd0, req.postbyte[0]};
      end
      c6309_pkg::MODE_ADDA: begin
        sum8 = {1'b0, a_reg} + {1'b0, req.data_bus};
        carries = a_reg ^ req.data_bus ^ sum8[7:0];
        cc_reg[c6309_pkg::CC_H] = carries[4];
        cc_reg[c6309_pkg::CC_N] = sum8[7];
        cc_reg[c6309_pkg::CC_Z] = (sum8[7:0] == 8'h00);
        cc_reg[c6309_pkg::CC_V] = (a_reg[7] ^ sum8[7]) & (req.data_bus[7] ^ sum8[7]);
        cc_reg[c6309_pkg::CC_C] = sum8[8];
        a_reg = sum8[7:0];
      end
      c6309_pkg::MODE_ADDD: begin
        d_val = {a_reg, b_reg};
        sum16 = {1'b0, d_val} + {1'b0, ea_reg};
        cc_reg[c6309_pkg::CC_N] = sum16[15];
        cc_reg[c6309_pkg::CC_Z] = (sum16[15:0] == 16'h0000);
        cc_reg[c6309_pkg::CC_V] = (d_val[15] ^ sum16[15]) & (ea_reg[15] ^ sum16[15]);
        cc_reg[c6309_pkg::CC_C] = sum16[16];
        {a_reg, b_reg} = sum16[15:0];
      end
      c6309_pkg::MODE_TFM: begin
        sel = req.postbyte[5:4];
        dst = req.postbyte[1:0];
        ptr_file[sel] = ptr_file[sel] + 16'd1;
        ptr_file[dst] = ptr_file[dst] + 16'd1;
        {e_reg, f_reg} = {e_reg, f_reg} - 16'd1;
      end
    endcase
    // The masks come from the condition codes as left by this microstate.
    pins_now = ~req.ctrl_lines_n;
    pend_reg[c6309_pkg::PEND_NMI]  = pend_reg[c6309_pkg::PEND_NMI] |
                                     (pins_now[0] & ~pins_last[0]);
    pend_reg[c6309_pkg::PEND_IRQ]  = pend_reg[c6309_pkg::PEND_IRQ] |
                                     (pins_now[1] & ~cc_reg[c6309_pkg::CC_I]);
    pend_reg[c6309_pkg::PEND_FIRQ] = pend_reg[c6309_pkg::PEND_FIRQ] |
                                     (pins_now[2] & ~cc_reg[c6309_pkg::CC_F]);
    pend_reg[c6309_pkg::PEND_HALT] = pend_reg[c6309_pkg::PEND_HALT] | ~req.halt_n;
    pins_last = pins_now;
    res = '{ea_reg, pend_reg, cc_reg, a_reg, b_reg};
    return res;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fault_count++;
    end
  endtask

  always @(posedge clk) begin : scoreboard
    c6309_pkg::in_item_t req;
    step_result_t        want;
    step_result_t        got;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        req.mode         = c6309_pkg::mode_t'(s_tuser);
        req.postbyte     = s_tdata[7:0];
        req.data_bus     = s_tdata[15:8];
        req.ctrl_lines_n = s_tdata[18:16];
        req.halt_n       = s_tdata[19];
        want = run_microstate(req);
        if (steps_issued < NDIR && DIRECTED[steps_issued].typed)
          want = DIRECTED[steps_issued].want;
        step_results_due.push_back(want);
        steps_issued++;
      end
      if (m_tvalid && m_tready) begin
        got = '{m_tdata[15:0], m_tdata[19:16], m_tdata[27:20], m_tdata[35:28],
                m_tdata[43:36]};
        if (step_results_due.size() == 0) begin
          $error("result with no request outstanding: %0h", m_tdata);
          fault_count++;
        end else begin
          want = step_results_due.pop_front();
          check_field("effective_addr", want.ea, got.ea);
          check_field("pending_out", 16'(want.pend), 16'(got.pend));
          check_field("cc_out", 16'(want.cc), 16'(got.cc));
          check_field("acc_a_out", 16'(want.acc_a), 16'(got.acc_a));
          check_field("acc_b_out", 16'(want.acc_b), 16'(got.acc_b));
        end
        steps_retired++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic offer(input c6309_pkg::in_item_t req);
    s_tvalid <= 1'b1;
    s_tuser  <= req.mode;
    s_tdata  <= {4'b0000, req.halt_n, req.ctrl_lines_n, req.data_bus, req.postbyte};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  initial begin : sink_side
    @(posedge clk iff !rst);
    forever begin
      if (!calm_phase && !backlog_done && steps_retired >= BACKLOG_AT) begin
        // Hold off long enough for the block to fill and stall its input.
        backlog_done = 1'b1;
        m_tready <= 1'b0;
        repeat (BACKLOG_LEN) @(posedge clk);
      end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  initial begin : source_side
    c6309_pkg::in_item_t req;
    int unsigned         k;
    @(posedge clk iff !rst);
    for (k = 0; k < NDIR; k++) begin
      req.mode         = DIRECTED[k].mode;
      req.postbyte     = DIRECTED[k].postbyte;
      req.data_bus     = DIRECTED[k].data_bus;
      req.ctrl_lines_n = DIRECTED[k].lines_n;
      req.halt_n       = DIRECTED[k].halt_n;
      offer(req);
    end
    for (k = 0; k < NRAND; k++) begin
      if (k == CALM_FROM)
        calm_phase = 1'b1;
      if (k == DRAIN_AT) begin
        s_tvalid <= 1'b0;
        do @(posedge clk); while (step_results_due.size() != 0);
      end else if (!calm_phase && $urandom_range(0, 7) == 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      req.mode         = c6309_pkg::mode_t'($urandom_range(0, 3));
      req.postbyte     = 8'($urandom);
      req.data_bus     = 8'($urandom);
      req.ctrl_lines_n = 3'($urandom);
      req.halt_n       = 1'($urandom);
      offer(req);
    end
    s_tvalid <= 1'b0;
    do @(posedge clk); while (step_results_due.size() != 0);
    repeat (10) @(posedge clk);
    if (fault_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
